// ----- rtl/sh_band4_euler_rotate_unit_macros.svh -----
// Assertion macros for the band-4 harmonic rotation unit.
// Used by the port checker; needs aclk and aresetn in scope.
`ifndef SH_BAND4_EULER_ROTATE_UNIT_MACROS_SVH
`define SH_BAND4_EULER_ROTATE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SHBER_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shber assertion failed");

// Next-cycle implication, disabled during reset.
`define SHBER_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shber assertion failed");

`endif

// ----- rtl/shber_pkg.sv -----
// Shared types, constants and arithmetic helpers for the band-4 rotation unit.
// No dependencies; imported by every module of the block but the port checker.
package shber_pkg;

    typedef logic signed [17:0] coef_t;
    typedef coef_t coef_arr_t [9];
    typedef logic signed [15:0] angle_t;
    typedef logic signed [17:0] trig_t;
    typedef trig_t trig_arr_t [4];
    typedef logic signed [20:0] mcoef_t;

    typedef enum logic [1:0] {
        MAT_Y90,
        MAT_YM90,
        MAT_X90,
        MAT_XM90
    } mat_sel_t;

    // delay line depths and valid pipeline length
    localparam int unsigned COEF_DLY = 12;
    localparam int unsigned AY_DLY   = 6;
    localparam int unsigned AZ_DLY   = 10;
    localparam int unsigned LAT      = 26;

    // Q20 matrix constants
    localparam mcoef_t KA   = 21'sd370728;
    localparam mcoef_t KB   = 21'sd980853;
    localparam mcoef_t KC   = 21'sd586172;
    localparam mcoef_t KD   = 21'sd775432;
    localparam mcoef_t KE   = 21'sd693568;
    localparam mcoef_t K375 = 21'sd393216;
    localparam mcoef_t K750 = 21'sd786432;
    localparam mcoef_t K125 = 21'sd131072;
    localparam mcoef_t K500 = 21'sd524288;
    localparam mcoef_t K0   = 21'sd0;

    localparam mcoef_t M_Y90 [9][9] = '{
        '{K0, KA, K0, KB, K0, K0, K0, K0, K0},
        '{-KA, K0, -KB, K0, K0, K0, K0, K0, K0},
        '{K0, KB, K0, -KA, K0, K0, K0, K0, K0},
        '{-KB, K0, KA, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K375, K0, -KC, K0, KD},
        '{K0, K0, K0, K0, K0, K750, K0, -KE, K0},
        '{K0, K0, K0, K0, -KC, K0, K500, K0, KE},
        '{K0, K0, K0, K0, K0, -KE, K0, -K750, K0},
        '{K0, K0, K0, K0, KD, K0, KE, K0, K125}
    };

    localparam mcoef_t M_YM90 [9][9] = '{
        '{K0, -KA, K0, -KB, K0, K0, K0, K0, K0},
        '{KA, K0, KB, K0, K0, K0, K0, K0, K0},
        '{K0, -KB, K0, KA, K0, K0, K0, K0, K0},
        '{KB, K0, -KA, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K375, K0, -KC, K0, KD},
        '{K0, K0, K0, K0, K0, K750, K0, -KE, K0},
        '{K0, K0, K0, K0, -KC, K0, K500, K0, KE},
        '{K0, K0, K0, K0, K0, -KE, K0, -K750, K0},
        '{K0, K0, K0, K0, KD, K0, KE, K0, K125}
    };

    localparam mcoef_t M_X90 [9][9] = '{
        '{K0, K0, K0, K0, K0, KB, K0, -KA, K0},
        '{K0, -K750, K0, KE, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K0, KA, K0, KB, K0},
        '{K0, KE, K0, K750, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K375, K0, KC, K0, KD},
        '{-KB, K0, -KA, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, KC, K0, K500, K0, -KE},
        '{KA, K0, -KB, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, KD, K0, -KE, K0, K125}
    };

    localparam mcoef_t M_XM90 [9][9] = '{
        '{K0, K0, K0, K0, K0, -KB, K0, KA, K0},
        '{K0, -K750, K0, KE, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K0, -KA, K0, -KB, K0},
        '{K0, KE, K0, K750, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, K375, K0, KC, K0, KD},
        '{KB, K0, KA, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, KC, K0, K500, K0, -KE},
        '{-KA, K0, KB, K0, K0, K0, K0, K0, K0},
        '{K0, K0, K0, K0, KD, K0, -KE, K0, K125}
    };

    // Taylor series divisors and their Q32 reciprocals
    localparam logic [5:0] DIV_S1 = 6'd42;
    localparam logic [5:0] DIV_S2 = 6'd20;
    localparam logic [5:0] DIV_S3 = 6'd6;
    localparam logic [5:0] DIV_C1 = 6'd56;
    localparam logic [5:0] DIV_C2 = 6'd30;
    localparam logic [5:0] DIV_C3 = 6'd12;
    localparam logic [29:0] RCP_S1 = 30'((64'd1 << 32) / 64'd42);
    localparam logic [29:0] RCP_S2 = 30'((64'd1 << 32) / 64'd20);
    localparam logic [29:0] RCP_S3 = 30'((64'd1 << 32) / 64'd6);
    localparam logic [29:0] RCP_C1 = 30'((64'd1 << 32) / 64'd56);
    localparam logic [29:0] RCP_C2 = 30'((64'd1 << 32) / 64'd30);
    localparam logic [29:0] RCP_C3 = 30'((64'd1 << 32) / 64'd12);
    localparam logic [30:0] ONE30  = 31'd1 << 30;

    function automatic mcoef_t mat_coef(input mat_sel_t sel, input int i, input int j);
        mcoef_t k;
        unique case (sel)
            MAT_Y90:  k = M_Y90[i][j];
            MAT_YM90: k = M_YM90[i][j];
            MAT_X90:  k = M_X90[i][j];
            MAT_XM90: k = M_XM90[i][j];
            default:  k = K0;
        endcase
        return k;
    endfunction

    // floor((v + 2^(n-1)) / 2^n), then clamp to 18 bits
    function automatic coef_t rnd_sat(input logic signed [47:0] v, input int unsigned n);
        logic signed [47:0] w;
        coef_t r;
        w = (v + (48'sd1 <<< (n - 1))) >>> n;
        if (w > 48'sd131071) begin
            r = 18'sd131071;
        end else if (w < -48'sd131072) begin
            r = -18'sd131072;
        end else begin
            r = coef_t'(w[17:0]);
        end
        return r;
    endfunction

    // estimate of x / d from the Q32 reciprocal; low by at most one
    function automatic logic [29:0] rcp_mul(input logic [29:0] x, input logic [29:0] rcp);
        logic [59:0] p;
        p = x * rcp;
        return 30'(p[59:32]);
    endfunction

    function automatic logic [29:0] div_fix(input logic [29:0] x, input logic [29:0] q0,
                                            input logic [5:0] d);
        logic [35:0] qd;
        logic [35:0] r;
        qd = q0 * d;
        r  = 36'(x) - qd;
        return (r >= 36'(d)) ? q0 + 30'd1 : q0;
    endfunction

    function automatic logic [30:0] one_minus(input logic [29:0] q);
        return ONE30 - 31'(q);
    endfunction

    function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] t);
        logic [60:0] p;
        p = a * t;
        return p[59:30];
    endfunction

    function automatic logic [16:0] rnd_q16(input logic [30:0] x);
        logic [30:0] s;
        s = x + 31'd8192;
        return s[30:14];
    endfunction

endpackage

// ----- rtl/sh_band4_euler_rotate_unit.sv -----
// Band-4 spherical harmonic rotation by three Euler angles (X, then Y, then Z).
// Input channel s_*: one item holds nine Q1.16 coefficients and three Q2.13
// angles; output channel m_*: one item holds the nine rotated coefficients.
// Between input accept and m_tvalid lie the 14-stage sine/cosine pipeline
// feeding the first Z stage and the 12 register stages of the remaining matrix
// and Z stages (each two stages deep).
// Throughput: one item per cycle; the pipeline takes an item in every cycle
// in which the output is empty or being taken.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds,
// s_tready drops and no item is lost or repeated.
// Reset: aresetn low synchronously clears all valid bits; data registers are
// not reset and their contents are dropped as invalid.
// Depends on shber_pkg, shber_sincos, shber_mat and shber_zrot.
module sh_band4_euler_rotate_unit import shber_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // coef_0..coef_8 (18 bits each), angle_x, angle_y, angle_z (16 bits each)
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_0..out_8 (18 bits each), zero fill to 168 bits
    output logic [167:0] m_tdata
);

    logic            ce;
    logic [LAT-1:0]  vld_reg;
    coef_arr_t       coef_in;
    angle_t          ax_in, ay_in, az_in;
    coef_arr_t       coef_dly_reg [COEF_DLY];
    angle_t          ay_dly_reg [AY_DLY];
    angle_t          az_dly_reg [AZ_DLY];
    angle_t          ang_src [3];
    trig_t           sn_w [3][4];
    trig_t           cs_w [3][4];
    coef_arr_t       c_a, c_b, c_c, c_d, c_e, c_f, c_g;

    // advance everything when the output slot is free or being taken
    assign ce       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[LAT-1];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            coef_in[k] = coef_t'(s_tdata[18*k +: 18]);
        end
        ax_in = angle_t'(s_tdata[177:162]);
        ay_in = angle_t'(s_tdata[193:178]);
        az_in = angle_t'(s_tdata[209:194]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // hold coefficients and later angles until their stage comes up
    always_ff @(posedge aclk) begin
        if (ce) begin
            coef_dly_reg[0] <= coef_in;
            for (int k = 1; k < COEF_DLY; k++) begin
                coef_dly_reg[k] <= coef_dly_reg[k - 1];
            end
            ay_dly_reg[0] <= ay_in;
            for (int k = 1; k < AY_DLY; k++) begin
                ay_dly_reg[k] <= ay_dly_reg[k - 1];
            end
            az_dly_reg[0] <= az_in;
            for (int k = 1; k < AZ_DLY; k++) begin
                az_dly_reg[k] <= az_dly_reg[k - 1];
            end
        end
    end

    assign ang_src[0] = ax_in;
    assign ang_src[1] = ay_dly_reg[AY_DLY-1];
    assign ang_src[2] = az_dly_reg[AZ_DLY-1];

    // one sine/cosine unit per axis and harmonic order (4 - k)
    for (genvar a = 0; a < 3; a++) begin : g_axis
        for (genvar k = 0; k < 4; k++) begin : g_ord
            shber_sincos u_sc (
                .aclk    (aclk),
                .ce      (ce),
                .angle   (ang_src[a]),
                .mult    (3'(4 - k)),
                .sin_out (sn_w[a][k]),
                .cos_out (cs_w[a][k])
            );
        end
    end

    // rotation about X
    shber_mat u_mat_ym90 (
        .aclk(aclk), .ce(ce), .sel(MAT_YM90), .c_in(coef_dly_reg[COEF_DLY-1]), .c_out(c_a)
    );
    shber_zrot u_zrot_x (
        .aclk(aclk), .ce(ce), .c_in(c_a), .sn_in(sn_w[0]), .cs_in(cs_w[0]), .c_out(c_b)
    );
    shber_mat u_mat_y90 (
        .aclk(aclk), .ce(ce), .sel(MAT_Y90), .c_in(c_b), .c_out(c_c)
    );

    // rotation about Y
    shber_mat u_mat_x90 (
        .aclk(aclk), .ce(ce), .sel(MAT_X90), .c_in(c_c), .c_out(c_d)
    );
    shber_zrot u_zrot_y (
        .aclk(aclk), .ce(ce), .c_in(c_d), .sn_in(sn_w[1]), .cs_in(cs_w[1]), .c_out(c_e)
    );
    shber_mat u_mat_xm90 (
        .aclk(aclk), .ce(ce), .sel(MAT_XM90), .c_in(c_e), .c_out(c_f)
    );

    // rotation about Z; its output registers are the output slot
    shber_zrot u_zrot_z (
        .aclk(aclk), .ce(ce), .c_in(c_f), .sn_in(sn_w[2]), .cs_in(cs_w[2]), .c_out(c_g)
    );

    always_comb begin
        m_tdata = '0;
        for (int k = 0; k < 9; k++) begin
            m_tdata[18*k +: 18] = c_g[k];
        end
    end

endmodule

// ----- rtl/shber_sincos.sv -----
// Pipelined fixed-point sine and cosine of mult * angle, 14 register stages.
// Depends on shber_pkg (reciprocals, divide correction, Q30 helpers).
module shber_sincos import shber_pkg::*; (
    input  logic        aclk,
    input  logic        ce,
    input  angle_t      angle,
    input  logic [2:0]  mult,
    output trig_t       sin_out,
    output trig_t       cos_out
);

    logic [15:0] ph_reg;
    logic [2:0]  oct_reg [2:13];
    logic [29:0] u_reg [2:11];
    logic [29:0] u2_reg [3:11];
    logic [29:0] q4s_reg, q4c_reg;
    logic [30:0] t5s_reg, t5c_reg;
    logic [29:0] p6s_reg, p6c_reg;
    logic [29:0] q7s_reg, q7c_reg, x7s_reg, x7c_reg;
    logic [30:0] t8s_reg, t8c_reg;
    logic [29:0] p9s_reg, p9c_reg;
    logic [29:0] q10s_reg, q10c_reg, x10s_reg, x10c_reg;
    logic [30:0] t11s_reg, t11c_reg;
    logic [29:0] s12_reg, p12c_reg;
    logic [16:0] s13_reg, c13_reg;
    trig_t       sin_reg, cos_reg;

    logic signed [18:0] theta;
    logic signed [36:0] ph_full;
    logic [13:0]        v;
    logic [29:0]        u_next;
    logic [59:0]        sq;
    logic [16:0]        sa, ca;
    trig_t              sin_next, cos_next;

    always_comb begin
        theta   = 19'(angle) * 19'($signed({1'b0, mult}));
        ph_full = 37'(theta) * 37'sd83443 + 37'sd32768;
        v       = ph_reg[13] ? 14'(14'd8192 - {1'b0, ph_reg[12:0]}) : {1'b0, ph_reg[12:0]};
        u_next  = 30'(v * 30'd102944);
        sq      = u_reg[2] * u_reg[2];
        // swap on odd octants, then restore quadrant signs
        sa = oct_reg[13][0] ? c13_reg : s13_reg;
        ca = oct_reg[13][0] ? s13_reg : c13_reg;
        case (oct_reg[13][2:1])
            2'd0: begin
                sin_next = trig_t'({1'b0, sa});
                cos_next = trig_t'({1'b0, ca});
            end
            2'd1: begin
                sin_next = trig_t'({1'b0, ca});
                cos_next = -trig_t'({1'b0, sa});
            end
            2'd2: begin
                sin_next = -trig_t'({1'b0, sa});
                cos_next = -trig_t'({1'b0, ca});
            end
            default: begin
                sin_next = -trig_t'({1'b0, ca});
                cos_next = trig_t'({1'b0, sa});
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            ph_reg     <= ph_full[31:16];
            oct_reg[2] <= ph_reg[15:13];
            u_reg[2]   <= u_next;
            for (int k = 3; k <= 13; k++) begin
                oct_reg[k] <= oct_reg[k - 1];
            end
            for (int k = 3; k <= 11; k++) begin
                u_reg[k] <= u_reg[k - 1];
            end
            u2_reg[3] <= sq[59:30];
            for (int k = 4; k <= 11; k++) begin
                u2_reg[k] <= u2_reg[k - 1];
            end
            // first series term
            q4s_reg  <= rcp_mul(u2_reg[3], RCP_S1);
            q4c_reg  <= rcp_mul(u2_reg[3], RCP_C1);
            t5s_reg  <= one_minus(div_fix(u2_reg[4], q4s_reg, DIV_S1));
            t5c_reg  <= one_minus(div_fix(u2_reg[4], q4c_reg, DIV_C1));
            p6s_reg  <= mul_q30(u2_reg[5], t5s_reg);
            p6c_reg  <= mul_q30(u2_reg[5], t5c_reg);
            // second series term
            q7s_reg  <= rcp_mul(p6s_reg, RCP_S2);
            q7c_reg  <= rcp_mul(p6c_reg, RCP_C2);
            x7s_reg  <= p6s_reg;
            x7c_reg  <= p6c_reg;
            t8s_reg  <= one_minus(div_fix(x7s_reg, q7s_reg, DIV_S2));
            t8c_reg  <= one_minus(div_fix(x7c_reg, q7c_reg, DIV_C2));
            p9s_reg  <= mul_q30(u2_reg[8], t8s_reg);
            p9c_reg  <= mul_q30(u2_reg[8], t8c_reg);
            // third series term
            q10s_reg <= rcp_mul(p9s_reg, RCP_S3);
            q10c_reg <= rcp_mul(p9c_reg, RCP_C3);
            x10s_reg <= p9s_reg;
            x10c_reg <= p9c_reg;
            t11s_reg <= one_minus(div_fix(x10s_reg, q10s_reg, DIV_S3));
            t11c_reg <= one_minus(div_fix(x10c_reg, q10c_reg, DIV_C3));
            s12_reg  <= mul_q30(u_reg[11], t11s_reg);
            p12c_reg <= mul_q30(u2_reg[11], t11c_reg);
            // round to Q16; cosine takes its last half term here
            s13_reg  <= rnd_q16(31'(s12_reg));
            c13_reg  <= rnd_q16(ONE30 - 31'(p12c_reg[29:1]));
            sin_reg  <= sin_next;
            cos_reg  <= cos_next;
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;

endmodule

// ----- rtl/shber_mat.sv -----
// Fixed 9x9 matrix stage: constant products summed, then rounded and clamped.
// Two register stages. Depends on shber_pkg (matrices, rnd_sat).
module shber_mat import shber_pkg::*; (
    input  logic      aclk,
    input  logic      ce,
    input  mat_sel_t  sel,
    input  coef_arr_t c_in,
    output coef_arr_t c_out
);

    logic signed [43:0] acc_reg [9];
    logic signed [43:0] acc_next [9];
    coef_arr_t          out_reg;

    always_comb begin
        logic signed [43:0] acc;
        logic signed [38:0] prod;
        for (int i = 0; i < 9; i++) begin
            acc = '0;
            for (int j = 0; j < 9; j++) begin
                prod = 39'(c_in[j]) * 39'(mat_coef(sel, i, j));
                acc  = acc + 44'(prod);
            end
            acc_next[i] = acc;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < 9; i++) begin
                acc_reg[i] <= acc_next[i];
                out_reg[i] <= rnd_sat(48'(acc_reg[i]), 20);
            end
        end
    end

    assign c_out = out_reg;

endmodule

// ----- rtl/shber_zrot.sv -----
// Z rotation stage: mixes pairs (k, 8-k) with cos/sin of (4-k) times the angle.
// Two register stages. Depends on shber_pkg (types, rnd_sat).
module shber_zrot import shber_pkg::*; (
    input  logic      aclk,
    input  logic      ce,
    input  coef_arr_t c_in,
    input  trig_arr_t sn_in,
    input  trig_arr_t cs_in,
    output coef_arr_t c_out
);

    logic signed [36:0] lo_reg [4];
    logic signed [36:0] hi_reg [4];
    logic signed [36:0] lo_next [4];
    logic signed [36:0] hi_next [4];
    coef_t              mid_reg;
    coef_arr_t          out_reg;

    always_comb begin
        logic signed [35:0] p_lc, p_hs, p_hc, p_ls;
        for (int i = 0; i < 4; i++) begin
            p_lc = c_in[i] * cs_in[i];
            p_hs = c_in[8 - i] * sn_in[i];
            p_hc = c_in[8 - i] * cs_in[i];
            p_ls = c_in[i] * sn_in[i];
            lo_next[i] = 37'(p_lc) + 37'(p_hs);
            hi_next[i] = 37'(p_hc) - 37'(p_ls);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            mid_reg    <= c_in[4];
            out_reg[4] <= mid_reg;
            for (int i = 0; i < 4; i++) begin
                lo_reg[i]      <= lo_next[i];
                hi_reg[i]      <= hi_next[i];
                out_reg[i]     <= rnd_sat(48'(lo_reg[i]), 16);
                out_reg[8 - i] <= rnd_sat(48'(hi_reg[i]), 16);
            end
        end
    end

    assign c_out = out_reg;

endmodule

// ----- rtl/sh_band4_euler_rotate_unit_checker.sv -----
// Port-level checker for the rotation unit, bound to the top level.
// Depends on sh_band4_euler_rotate_unit_macros.svh.
`include "sh_band4_euler_rotate_unit_macros.svh"

module sh_band4_euler_rotate_unit_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [167:0] m_tdata
);

    `SHBER_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `SHBER_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    `SHBER_ASSERT_NOW(a_ready_follows_out, 1'b1, s_tready == (!m_tvalid || m_tready))
    `SHBER_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[167:162] == 6'd0)

endmodule

bind sh_band4_euler_rotate_unit sh_band4_euler_rotate_unit_checker u_shber_chk (.*);
